// ===== src/dadw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dadw_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned SYEAR_W  = 14;
  localparam int unsigned ADD_W    = 16;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned ACC_W    = 17;
  localparam int unsigned YEAR_W   = 15;
  localparam int unsigned CENT_W   = 8;
  localparam int unsigned DIV_W    = 15;
  localparam int unsigned DVS_W    = 7;
  localparam int unsigned SUM_W    = 11;
  localparam int unsigned RCP_W    = 17;
  localparam int unsigned RCP_SH   = 19;
  localparam int unsigned MUL_W    = DIV_W + RCP_W;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DVS_W-1:0]   DIV_CENT  = 7'd100;
  localparam logic [DVS_W-1:0]   DIV_WEEK  = 7'd7;
  localparam logic [DVS_W-1:0]   LAST_REM  = 7'd99;

  // ceil(2^19 / divisor), exact for any 15-bit dividend
  localparam logic [RCP_W-1:0]   RCP_CENT  = 17'd5243;
  localparam logic [RCP_W-1:0]   RCP_WEEK  = 17'd74899;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [SYEAR_W-1:0] start_year;
    logic [ADD_W-1:0]   days_to_add;
  } in_word_t;

  typedef struct packed {
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [SYEAR_W-1:0] new_year;
    logic [WDAY_W-1:0]  weekday;
    logic               year_overflow;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVY,
    ST_WALK,
    ST_SUM,
    ST_MOD,
    ST_FIN
  } state_e;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(13 * (mm + 1) / 5) for zeller months 3..14
  function automatic logic [5:0] zel_month(input logic [MONTH_W-1:0] mm);
    logic [5:0] v;
    case (mm)
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      4'd13:   v = 6'd36;
      4'd14:   v = 6'd39;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/dadw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dadw_div
  import dadw_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic             mul_q, mul_d;
  logic             fix_q, fix_d;
  logic             done_q, done_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [MUL_W-1:0] prod_q, prod_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [RCP_W-1:0] rcp;
  logic [DIV_W-1:0] quo;

  // load, multiply by reciprocal, then quotient and remainder
  always_comb begin
    mul_d  = 1'b0;
    fix_d  = mul_q;
    done_d = fix_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    prod_d = prod_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    rcp    = (dvs_q == DIV_WEEK) ? RCP_WEEK : RCP_CENT;
    quo    = DIV_W'(prod_q[MUL_W-1:RCP_SH]);
    if (req_i.start) begin
      mul_d = 1'b1;
      dvd_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end
    if (mul_q) begin
      prod_d = MUL_W'(dvd_q) * MUL_W'(rcp);
    end
    if (fix_q) begin
      quo_d = quo;
      rem_d = DVS_W'(dvd_q - DIV_W'(quo * DIV_W'(dvs_q)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= mul_d;
      fix_q  <= fix_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== src/date_add_days_weekday_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  handshake                 word
// input    in_valid_i / in_ready_o   in_word_i  (start date, days to add)
// output   out_valid_o / out_ready_i out_word_o (new date, weekday, overflow)
//
// the sequencer walks the months crossed one at a time, so a long addition takes longest
// the block finishes one word before it takes the next
// a shared reciprocal divider gives year / 100 and the weekday mod 7
// reset clears the sequencer, the divider control and the output valid
// the input is taken again while a finished word still waits on the output

module date_add_days_weekday_top
  import dadw_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o
);

  localparam logic [YEAR_W:0]    MAX_Y_EXT = (YEAR_W + 1)'(MAX_YEAR);
  localparam logic [SYEAR_W-1:0] MAX_Y_OUT = SYEAR_W'(MAX_YEAR);

  state_e state_q, state_d;

  logic [ACC_W-1:0]   day_q, day_d;
  logic [MONTH_W-1:0] mon_q, mon_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [CENT_W-1:0]  cent_q, cent_d;
  logic [DVS_W-1:0]   yrem_q, yrem_d;
  logic [WDAY_W-1:0]  wday_q, wday_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_acc;
  logic               out_free;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               more;
  logic               early;
  logic [DVS_W-1:0]   zk;
  logic [CENT_W-1:0]  zj;
  logic [MONTH_W-1:0] zm;
  logic [SUM_W-1:0]   zsum;
  logic [DAY_W-1:0]   d0;
  logic [MONTH_W-1:0] m0;
  logic [YEAR_W-1:0]  y0;
  logic               ovf;

  dadw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // leap test from the year kept as centuries and remainder
  assign leap = (yrem_q == '0) ? (cent_q[1:0] == 2'b00) : (yrem_q[1:0] == 2'b00);
  assign mlen = month_len(mon_q, leap);
  assign more = (day_q > {{(ACC_W-DAY_W){1'b0}}, mlen});

  // zeller terms, year taken back by one for january and february
  always_comb begin
    early = (mon_q < MONTH_MAR);
    zk    = yrem_q;
    zj    = cent_q;
    zm    = mon_q;
    if (early) begin
      zm = mon_q + MONTH_DEC;
      if (yrem_q == '0) begin
        zk = LAST_REM;
        zj = cent_q - 1'b1;
      end else begin
        zk = yrem_q - 1'b1;
      end
    end
    zsum = SUM_W'(day_q[DAY_W-1:0]) + SUM_W'(zel_month(zm)) + SUM_W'(zk)
         + SUM_W'(zk[DVS_W-1:2]) + SUM_W'(zj[CENT_W-1:2])
         + SUM_W'({zj, 2'b00}) + SUM_W'(zj);
  end

  always_comb begin
    d0 = (in_word_i.start_day == '0) ? DAY_W'(1) : in_word_i.start_day;
    m0 = in_word_i.start_month;
    if (m0 == '0) begin
      m0 = MONTH_JAN;
    end else if (m0 > MONTH_DEC) begin
      m0 = MONTH_DEC;
    end
    y0 = (in_word_i.start_year == '0) ? YEAR_W'(1) : YEAR_W'(in_word_i.start_year);
  end

  assign ovf = ({1'b0, year_q} > MAX_Y_EXT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_DIVY;
      ST_DIVY: if (div_rsp.done) state_d = ST_WALK;
      ST_WALK: if (!more) state_d = ST_SUM;
      ST_SUM:  state_d = ST_MOD;
      ST_MOD:  if (div_rsp.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(year_q);
    div_req.divisor  = DIV_CENT;
    day_d            = day_q;
    mon_d            = mon_q;
    year_d           = year_q;
    cent_d           = cent_q;
    yrem_d           = yrem_q;
    wday_d           = wday_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc) begin
          day_d            = ACC_W'(d0) + ACC_W'(in_word_i.days_to_add);
          mon_d            = m0;
          year_d           = y0;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(y0);
        end
      end
      ST_DIVY: begin
        if (div_rsp.done) begin
          cent_d = div_rsp.quo[CENT_W-1:0];
          yrem_d = div_rsp.rem;
        end
      end
      ST_WALK: begin
        if (more) begin
          day_d = day_q - ACC_W'(mlen);
          if (mon_q == MONTH_DEC) begin
            mon_d  = MONTH_JAN;
            year_d = year_q + 1'b1;
            if (yrem_q == LAST_REM) begin
              yrem_d = '0;
              cent_d = cent_q + 1'b1;
            end else begin
              yrem_d = yrem_q + 1'b1;
            end
          end else begin
            mon_d = mon_q + 1'b1;
          end
        end
      end
      ST_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(zsum);
        div_req.divisor  = DIV_WEEK;
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          wday_d = div_rsp.rem[WDAY_W-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.new_day       = day_q[DAY_W-1:0];
          out_d.new_month     = mon_q;
          out_d.new_year      = ovf ? MAX_Y_OUT : year_q[SYEAR_W-1:0];
          out_d.weekday       = wday_q;
          out_d.year_overflow = ovf;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    cent_q <= cent_d;
    yrem_q <= yrem_d;
    wday_q <= wday_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== src/dadw_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dadw_chk
  import dadw_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_word_o
);

  localparam logic [SYEAR_W-1:0] MAX_Y_OUT = SYEAR_W'(MAX_YEAR);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // an accepted word keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after accept");

  // a new result only appears while the block is busy
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in flight");

  // result fields in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.new_month != '0) && (out_word_o.new_month <= 4'd12)
      && (out_word_o.new_day != '0) && (out_word_o.weekday <= 3'd6))
    else $error("result field out of range");

  // overflow clamps the year
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.year_overflow |-> out_word_o.new_year == MAX_Y_OUT)
    else $error("overflow without clamped year");

endmodule

bind date_add_days_weekday_top dadw_chk #(.MAX_YEAR(MAX_YEAR)) u_dadw_chk (.*);

`default_nettype wire

// ===== sim/date_add_days_weekday_top_test.sv =====
`timescale 1ns / 1ps

module date_add_days_weekday_top_test;
  import dadw_pkg::*;

  localparam int unsigned YEAR_LIMIT   = 9999;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 2500;
  localparam int unsigned MAX_SHOWN    = 10;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  out_word_t   pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent     = 0;
  int unsigned words_checked  = 0;
  int unsigned overflow_words = 0;
  int unsigned long_adds      = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_taken    = 0;
  int unsigned hold_left      = 0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;

  date_add_days_weekday_top #(
    .MAX_YEAR(YEAR_LIMIT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    int unsigned len;
    case (m)
      4, 6, 9, 11: len = 30;
      MONTH_FEB:   len = leap_year(y) ? 29 : 28;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // zeller: jan and feb count as months 13 and 14 of the year before
  function automatic logic [WDAY_W-1:0] zeller_weekday(input int unsigned d,
                                                       input int unsigned m,
                                                       input int unsigned y);
    int unsigned mm;
    int unsigned yy;
    int unsigned k;
    int unsigned j;
    mm = m;
    yy = y;
    if (mm < MONTH_MAR) begin
      mm += 12;
      yy -= 1;
    end
    k = yy % 100;
    j = yy / 100;
    return WDAY_W'((d + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
  endfunction

  function automatic out_word_t date_after(input in_word_t req);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned len;
    out_word_t   res;
    d = req.start_day;
    m = req.start_month;
    y = req.start_year;
    if (d == 0) d = 1;
    if (m == 0) m = MONTH_JAN;
    if (m > MONTH_DEC) m = MONTH_DEC;
    if (y == 0) y = 1;
    d += req.days_to_add;
    len = days_in_month(m, y);
    while (d > len) begin
      d -= len;
      m++;
      if (m > MONTH_DEC) begin
        m = MONTH_JAN;
        y++;
      end
      len = days_in_month(m, y);
    end
    res.new_day       = DAY_W'(d);
    res.new_month     = MONTH_W'(m);
    res.year_overflow = (y > YEAR_LIMIT);
    res.new_year      = SYEAR_W'(res.year_overflow ? YEAR_LIMIT : y);
    res.weekday       = zeller_weekday(d, m, y);
    return res;
  endfunction

  function automatic in_word_t date_word(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input int unsigned add);
    in_word_t w;
    w.start_day   = DAY_W'(d);
    w.start_month = MONTH_W'(m);
    w.start_year  = SYEAR_W'(y);
    w.days_to_add = ADD_W'(add);
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 200);
  endfunction

  function automatic in_word_t random_request();
    in_word_t    w;
    int unsigned m;
    int unsigned y;
    int unsigned r;
    if ($urandom_range(0, 99) < 80) begin
      m = $urandom_range(MONTH_JAN, MONTH_DEC);
      case ($urandom_range(0, 9))
        0:       y = 100 * $urandom_range(1, 99);
        1:       y = $urandom_range(YEAR_LIMIT - 9, YEAR_LIMIT);
        default: y = $urandom_range(1, YEAR_LIMIT);
      endcase
      w = date_word($urandom_range(1, days_in_month(m, y)), m, y, 0);
    end else begin
      // raw fields of any bit pattern, out-of-range values included
      w.start_day   = DAY_W'($urandom);
      w.start_month = MONTH_W'($urandom);
      w.start_year  = SYEAR_W'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 65) w.days_to_add = ADD_W'($urandom_range(0, 400));
    else if (r < 90) w.days_to_add = ADD_W'($urandom_range(0, 4000));
    else w.days_to_add = ADD_W'($urandom);
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pending_dates.push_back(date_after(w));
    words_sent++;
    if (w.days_to_add > 4000) long_adds++;
  endtask

  task automatic check_field(input string field, input logic [SYEAR_W-1:0] want,
                             input logic [SYEAR_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
        $display("word %0d: %s expected %0d, got %0d", words_checked, field, want, got);
    end
  endtask

  task automatic test_field_extremes();
    send_word(date_word(1, 1, 1, 0), pick_gap());
    send_word(date_word(1, 1, 1, 65535), pick_gap());
    send_word(date_word(31, 12, 9999, 65535), pick_gap());
    send_word(date_word(31, 15, 16383, 65535), pick_gap());
    send_word(date_word(15, 7, 5000, 32768), pick_gap());
  endtask

  task automatic test_special_cases();
    send_word(date_word(0, 0, 0, 0), pick_gap());
    send_word(date_word(0, 5, 2020, 3), pick_gap());
    send_word(date_word(31, 13, 2021, 0), pick_gap());
    send_word(date_word(31, 2, 2023, 0), pick_gap());
    send_word(date_word(31, 12, 9999, 1), pick_gap());
    send_word(date_word(1, 1, 12000, 0), pick_gap());
  endtask

  task automatic test_leap_and_weekday();
    send_word(date_word(28, 2, 1900, 1), pick_gap());
    send_word(date_word(28, 2, 2000, 1), pick_gap());
    send_word(date_word(28, 2, 2024, 1), pick_gap());
    send_word(date_word(29, 2, 2000, 365), pick_gap());
    send_word(date_word(1, 1, 2024, 0), pick_gap());
    send_word(date_word(14, 2, 2024, 0), pick_gap());
    send_word(date_word(1, 1, 100, 0), pick_gap());
    send_word(date_word(1, 3, 400, 0), pick_gap());
    send_word(date_word(31, 12, 1999, 1), pick_gap());
  endtask

  // output held long while words keep coming, so the input stalls
  task automatic test_backpressure();
    holds_asked++;
    repeat (12) send_word(date_word($urandom_range(1, 28), $urandom_range(1, 12),
                                    $urandom_range(1, 9999), $urandom_range(0, 200)), 0);
  endtask

  task automatic test_random_dates();
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_word(random_request(), pick_gap());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      out_ready_i <= 1'b0;
      hold_left   <= LONG_HOLD;
      holds_taken <= holds_taken + 1;
    end else if (rx_steady || $urandom_range(0, 99) < 65) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b0;
      hold_left   <= ($urandom_range(0, 99) < 95) ? $urandom_range(0, 4)
                                                  : $urandom_range(20, 150);
    end
  end

  always @(posedge clk_i) begin : check_words
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected word: %p", out_word_o);
      end else begin
        want = pending_dates.pop_front();
        check_field("new_day", SYEAR_W'(want.new_day), SYEAR_W'(out_word_o.new_day));
        check_field("new_month", SYEAR_W'(want.new_month), SYEAR_W'(out_word_o.new_month));
        check_field("new_year", want.new_year, out_word_o.new_year);
        check_field("weekday", SYEAR_W'(want.weekday), SYEAR_W'(out_word_o.weekday));
        check_field("year_overflow", SYEAR_W'(want.year_overflow),
                    SYEAR_W'(out_word_o.year_overflow));
        if (want.year_overflow) overflow_words++;
      end
      words_checked++;
    end
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d words outstanding", pending_dates.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_special_cases();
    test_leap_and_weekday();
    test_backpressure();
    test_random_dates();
    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d dates sent and %0d checked, %0d ran past the year limit", words_sent,
             words_checked, overflow_words);
    $display("%0d long additions, %0d long output holds, %0d mismatches", long_adds,
             holds_taken, mismatch_count);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
